// File: hw/rtl/xcfr_pkg.sv
package xcfr_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned CountW = 2;
  localparam int unsigned PhaseW = 3;
  localparam int unsigned BodyW  = 3;
  localparam int unsigned BodyDepth = 4;

  localparam logic [ByteW-1:0] MaxPayload = 8'd2;

  localparam logic [PhaseW-1:0] PhIdle = 3'd0;
  localparam logic [PhaseW-1:0] PhCmd  = 3'd1;
  localparam logic [PhaseW-1:0] PhLen  = 3'd2;
  localparam logic [PhaseW-1:0] PhBody = 3'd3;
  localparam logic [PhaseW-1:0] PhEnd  = 3'd4;

  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] RegStartByte = 2'd0;
  localparam logic [CfgIdxW-1:0] RegEndByte   = 2'd1;

  typedef struct packed {
    logic [ByteW-1:0]  command;
    logic [CountW-1:0] payload_count;
    logic [ByteW-1:0]  payload_first;
    logic [ByteW-1:0]  payload_second;
  } xcfr_result_t;

endpackage

// File: hw/rtl/xcfr_parser.sv
module xcfr_parser (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      accept_i,
  input  logic [xcfr_pkg::ByteW-1:0] rx_byte_i,
  input  logic [xcfr_pkg::ByteW-1:0] start_byte_i,
  input  logic [xcfr_pkg::ByteW-1:0] end_byte_i,
  output logic                      res_valid_o,
  output xcfr_pkg::xcfr_result_t    res_o
);
  import xcfr_pkg::*;

  logic [PhaseW-1:0] phase_q, phase_d;
  logic [BodyW-1:0]  count_q, count_d;
  logic [ByteW-1:0]  cmd_q, cmd_d;
  logic [CountW-1:0] len_q, len_d;
  logic [ByteW-1:0]  body_q [BodyDepth];
  logic              body_we;
  logic [ByteW-1:0]  first_byte, second_byte, check_sum;
  logic [BodyW-1:0]  count_inc, body_last;

  assign first_byte  = (len_q >= 2'd1) ? body_q[0] : '0;
  assign second_byte = (len_q >= 2'd2) ? body_q[1] : '0;
  assign check_sum   = cmd_q ^ {{(ByteW-CountW){1'b0}}, len_q} ^ first_byte ^ second_byte;
  assign count_inc   = count_q + 3'd1;
  assign body_last   = {1'b0, len_q} + 3'd2;

  always_comb begin
    phase_d     = phase_q;
    count_d     = count_q;
    cmd_d       = cmd_q;
    len_d       = len_q;
    body_we     = 1'b0;
    res_valid_o = 1'b0;
    if (accept_i) begin
      if (rx_byte_i == start_byte_i) begin
        phase_d = PhCmd;
      end else begin
        case (phase_q)
          PhCmd: begin
            cmd_d   = rx_byte_i;
            phase_d = PhLen;
          end
          PhLen: begin
            if (rx_byte_i > MaxPayload) begin
              phase_d = PhIdle;
            end else begin
              len_d   = rx_byte_i[CountW-1:0];
              count_d = '0;
              phase_d = PhBody;
            end
          end
          PhBody: begin
            body_we = 1'b1;
            count_d = count_inc;
            if (count_inc >= body_last) phase_d = PhEnd;
          end
          PhEnd: begin
            phase_d = PhIdle;
            if (rx_byte_i == end_byte_i && check_sum == body_q[len_q]) res_valid_o = 1'b1;
          end
          default: ;
        endcase
      end
    end
  end

  assign res_o.command        = cmd_q;
  assign res_o.payload_count  = len_q;
  assign res_o.payload_first  = first_byte;
  assign res_o.payload_second = second_byte;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      count_q <= '0;
      cmd_q   <= '0;
      len_q   <= '0;
    end else begin
      phase_q <= phase_d;
      count_q <= count_d;
      cmd_q   <= cmd_d;
      len_q   <= len_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (body_we) body_q[count_q[1:0]] <= rx_byte_i;
  end

endmodule

// File: hw/rtl/xcfr_out_reg.sv
module xcfr_out_reg (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   load_i,
  input  xcfr_pkg::xcfr_result_t data_i,
  input  logic                   ready_i,
  output logic                   valid_o,
  output logic                   free_o,
  output xcfr_pkg::xcfr_result_t data_o
);
  import xcfr_pkg::*;

  logic         valid_q, valid_d;
  xcfr_result_t data_q;

  assign free_o  = !valid_q || ready_i;
  assign valid_d = load_i ? 1'b1 : (ready_i ? 1'b0 : valid_q);
  assign valid_o = valid_q;
  assign data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) data_q <= data_i;
  end

endmodule

// File: hw/rtl/xor_checked_frame_receiver.sv
// Byte-serial frame receiver: start byte, command, length (0 to 2), payload, XOR check byte,
// one pad byte, end byte. One byte is taken per cycle and the frame state is updated on each
// transfer; a frame whose end byte and XOR check both match yields one result, held in an
// output register, on the cycle after its end byte. Input ready stays high unless that
// register holds a result the consumer has not taken. The start byte resyncs the parser
// in any phase; user sets start and end byte values via config port while idle (unchecked).
module xor_checked_frame_receiver (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [xcfr_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [xcfr_pkg::ByteW-1:0]   cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [xcfr_pkg::ByteW-1:0]   rx_byte_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [xcfr_pkg::ByteW-1:0]   command_o,
  output logic [xcfr_pkg::CountW-1:0]  payload_count_o,
  output logic [xcfr_pkg::ByteW-1:0]   payload_first_o,
  output logic [xcfr_pkg::ByteW-1:0]   payload_second_o
);
  import xcfr_pkg::*;

  logic [ByteW-1:0] start_byte_q, end_byte_q;
  logic             accept, res_valid, free;
  xcfr_result_t     res, out_data;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = free;
  assign accept      = in_valid_i && free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_byte_q <= 8'd170;
      end_byte_q   <= 8'd85;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == RegStartByte) start_byte_q <= cfg_data_i;
      if (cfg_index_i == RegEndByte)   end_byte_q   <= cfg_data_i;
    end
  end

  xcfr_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .rx_byte_i   (rx_byte_i),
    .start_byte_i(start_byte_q),
    .end_byte_i  (end_byte_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  xcfr_out_reg u_out_reg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (res_valid),
    .data_i (res),
    .ready_i(out_ready_i),
    .valid_o(out_valid_o),
    .free_o (free),
    .data_o (out_data)
  );

  assign command_o        = out_data.command;
  assign payload_count_o  = out_data.payload_count;
  assign payload_first_o  = out_data.payload_first;
  assign payload_second_o = out_data.payload_second;

endmodule

// File: hw/rtl/xcfr_checker.sv
module xcfr_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] command_o,
  input logic [1:0] payload_count_o,
  input logic [7:0] payload_first_o,
  input logic [7:0] payload_second_o
);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(command_o))
    else $error("stalled result dropped or changed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> payload_count_o != 2'd3)
    else $error("payload count out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && payload_count_o == 2'd0 |-> payload_first_o == 8'd0 && payload_second_o == 8'd0)
    else $error("unused payload bytes not zero");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without a pending result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o))
    else $error("result without an input transfer");

endmodule

bind xor_checked_frame_receiver xcfr_checker u_xcfr_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_ready_o      (in_ready_o),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .command_o       (command_o),
  .payload_count_o (payload_count_o),
  .payload_first_o (payload_first_o),
  .payload_second_o(payload_second_o)
);
